// ----- rtl/sli_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and sizing for the sorted insertion list.
// No dependencies; used by sli_cell, sorted_list_insert_delete, sli_list_monitor and the testbench top.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int SIZE_W   = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Broadcast to every cell for the beat being accepted.
    typedef struct packed {
        logic   insert;
        logic   del;
        logic   found;
        value_t value;
    } cell_ctrl_t;

endpackage

// ----- rtl/sli_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted list: holds an entry, compares it with the command
// value and shifts toward either neighbor. Depends on sli_pkg.
module sli_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  sli_pkg::cell_ctrl_t ctrl,
    input  logic                left_keep,
    input  logic                left_valid,
    input  sli_pkg::value_t     left_entry,
    input  logic                right_valid,
    input  sli_pkg::value_t     right_entry,
    output logic                keep,
    output logic                match,
    output logic                valid,
    output sli_pkg::value_t     entry
);

    sli_pkg::value_t entry_reg;
    sli_pkg::value_t entry_next;
    logic            valid_reg;
    logic            valid_next;
    logic            load;

    // keep: this entry sorts strictly below the value and stays put
    assign keep  = valid_reg && (entry_reg < ctrl.value);
    assign match = valid_reg && (entry_reg == ctrl.value);
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_comb
    begin
        load       = 1'b0;
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.insert && !keep)
        begin
            // first non-keep slot takes the new value, the rest move right
            load       = 1'b1;
            entry_next = left_keep ? ctrl.value : left_entry;
            valid_next = left_valid;
        end
        else if (ctrl.del && ctrl.found && !keep)
        begin
            // from the first match onward everything moves left
            load       = 1'b1;
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// Sorted insertion list: a row of sli_cell slots, all compared in parallel.
// The result beat is registered and appears in the cycle after the command beat.
// Throughput: one command per cycle while results drain; each cell compares and
// shifts once per beat. Reset: list empty, no result pending; entry storage
// itself is not cleared. Depends on sli_pkg and sli_cell.
module sorted_list_insert_delete
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command[1:0], value[33:2], position[37:34], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status[1:0], read_value[33:2], size[38:34], zero
);

    localparam int CAP = sli_pkg::CAPACITY;

    logic                         accept;
    sli_pkg::cmd_t                cmd;
    sli_pkg::value_t              value;
    logic [sli_pkg::POS_W-1:0]    pos;
    sli_pkg::cell_ctrl_t          ctrl;
    logic                         has_room;

    logic [CAP-1:0]               keep_vec;
    logic [CAP-1:0]               match_vec;
    logic [CAP-1:0]               valid_vec;
    sli_pkg::value_t              entry_vec [CAP];

    logic [CAP:0]                 lkeep;
    logic [CAP:0]                 lvalid;
    sli_pkg::value_t              lentry [CAP+1];
    logic [CAP:0]                 rvalid;
    sli_pkg::value_t              rentry [CAP+1];

    logic [sli_pkg::OCC_W-1:0]    occ_reg;
    logic [sli_pkg::OCC_W-1:0]    occ_next;
    sli_pkg::status_t             status;
    sli_pkg::value_t              rd_value;
    logic                         rd_hit;
    sli_pkg::value_t              rd_sel;

    logic                         out_valid_reg;
    logic [39:0]                  out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = sli_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign value         = s_axis_tdata[33:2];
    assign pos           = s_axis_tdata[37:34];
    assign has_room      = occ_reg < sli_pkg::OCC_W'(CAP);

    assign ctrl.insert = accept && (cmd == sli_pkg::CMD_INSERT) && has_room;
    assign ctrl.del    = accept && (cmd == sli_pkg::CMD_DELETE);
    assign ctrl.found  = |match_vec;
    assign ctrl.value  = value;

    // neighbor links; the head acts as if a smaller entry sat to its left
    assign lkeep[0]    = 1'b1;
    assign lvalid[0]   = 1'b1;
    assign lentry[0]   = value;
    assign rvalid[CAP] = 1'b0;
    assign rentry[CAP] = value;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        assign lkeep[i+1]  = keep_vec[i];
        assign lvalid[i+1] = valid_vec[i];
        assign lentry[i+1] = entry_vec[i];
        assign rvalid[i]   = valid_vec[i];
        assign rentry[i]   = entry_vec[i];

        sli_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_keep   (lkeep[i]),
            .left_valid  (lvalid[i]),
            .left_entry  (lentry[i]),
            .right_valid (rvalid[i+1]),
            .right_entry (rentry[i+1]),
            .keep        (keep_vec[i]),
            .match       (match_vec[i]),
            .valid       (valid_vec[i]),
            .entry       (entry_vec[i])
        );
    end

    // read select; valid bits form a thermometer so valid means pos < size
    always_comb
    begin
        rd_hit = 1'b0;
        rd_sel = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if ((int'(pos) == i) && valid_vec[i])
            begin
                rd_hit = 1'b1;
                rd_sel = entry_vec[i];
            end
        end
    end

    always_comb
    begin
        status   = sli_pkg::ST_MISS;
        rd_value = '0;
        occ_next = occ_reg;
        case (cmd)
            sli_pkg::CMD_INSERT:
            begin
                if (has_room)
                begin
                    status   = sli_pkg::ST_OK;
                    occ_next = occ_reg + sli_pkg::OCC_W'(1);
                end
                else
                begin
                    status = sli_pkg::ST_FULL;
                end
            end
            sli_pkg::CMD_DELETE:
            begin
                if (ctrl.found)
                begin
                    status   = sli_pkg::ST_OK;
                    occ_next = occ_reg - sli_pkg::OCC_W'(1);
                end
            end
            sli_pkg::CMD_READ:
            begin
                if (rd_hit)
                begin
                    status   = sli_pkg::ST_OK;
                    rd_value = rd_sel;
                end
            end
            default:
            begin
                status = sli_pkg::ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {1'b0, sli_pkg::SIZE_W'(occ_next), rd_value, status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= sli_pkg::OCC_W'(CAP))
        else $error("occupancy above capacity");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("cell valid bits disagree with occupancy");

    a_size_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[38:34] == sli_pkg::SIZE_W'(occ_reg)))
        else $error("pending size differs from occupancy");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == sli_pkg::CMD_INSERT) && has_room)
        |=> (occ_reg == $past(occ_reg) + sli_pkg::OCC_W'(1)))
        else $error("insert did not grow the list");

endmodule

// ----- test/sli_list_monitor.sv -----
`timescale 1ns / 1ps
// Result monitor for the sorted insertion list: mirrors the list from command beats
// and compares every result beat with the oldest outstanding prediction.
// Depends on sli_pkg.
module sli_list_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command[1:0], value[33:2], position[37:34], zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // status[1:0], read_value[33:2], size[38:34], zero
    output int          error_count,
    output int          pending,
    output int          results_checked,
    output int          full_count,
    output int          miss_count
);
    import sli_pkg::*;

    typedef struct {
        status_t           status;
        value_t            read_value;
        logic [SIZE_W-1:0] size;
    } list_result_t;

    value_t       held_q[$];      // mirror of the list, ascending
    list_result_t expected_q[$];  // predicted result beats, oldest first

    function automatic list_result_t apply_command(input logic [1:0] op, input value_t val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t res;
        int           below;
        int           idx;
        res.status     = ST_MISS;
        res.read_value = '0;
        below          = 0;
        case (op)
            CMD_INSERT:
            begin
                if (held_q.size() >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // new value goes ahead of any equal entries
                    foreach (held_q[i])
                        if (held_q[i] < val)
                            below++;
                    held_q.insert(below, val);
                    res.status = ST_OK;
                end
            end
            CMD_DELETE:
            begin
                for (idx = 0; idx < held_q.size(); idx++)
                begin
                    if (held_q[idx] == val)
                    begin
                        held_q.delete(idx);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            CMD_READ:
            begin
                if (pos < held_q.size())
                begin
                    res.read_value = held_q[pos];
                    res.status     = ST_OK;
                end
            end
            default: ;  // unused code leaves the list alone
        endcase
        res.size = SIZE_W'(held_q.size());
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            held_q.delete();
            expected_q.delete();
            error_count     = 0;
            results_checked = 0;
            full_count      = 0;
            miss_count      = 0;
            pending        <= 0;
        end
        else
        begin
            // result side first: a result can never belong to a command of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d read_value %0d size %0d",
                           m_axis_tdata[1:0], $signed(m_axis_tdata[33:2]), m_axis_tdata[38:34]);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[33:2] !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d", want.read_value,
                               $signed(m_axis_tdata[33:2]));
                        error_count++;
                    end
                    if (m_axis_tdata[38:34] !== want.size)
                    begin
                        $error("size: expected %0d, got %0d", want.size, m_axis_tdata[38:34]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = apply_command(s_axis_tdata[1:0], value_t'(s_axis_tdata[33:2]),
                                     s_axis_tdata[37:34]);
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_MISS)
                    miss_count++;
                expected_q.push_back(want);
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ----- test/tb_sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// Testbench top for sorted_list_insert_delete: drives command beats and result
// back-pressure, runs the watchdog and reports the verdict. Depends on sli_pkg,
// the block itself and sli_list_monitor.
module tb_sorted_list_insert_delete;
    import sli_pkg::*;

    localparam int         RESET_CYCLES     = 11;
    localparam int         RANDOM_PER_PHASE = 217;
    localparam int         STALL_LIMIT      = 2000;
    localparam int         TAIL_CYCLES      = 4;
    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam value_t     VAL_MIN          = 32'sh8000_0000;
    localparam value_t     VAL_MAX          = 32'sh7FFF_FFFF;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // command[1:0], value[33:2], position[37:34], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // status[1:0], read_value[33:2], size[38:34], zero

    int src_idle_pct  = 13;
    int sink_idle_pct = 61;
    int commands_sent = 0;
    int stall_cycles  = 0;
    int error_count;
    int pending;
    int results_checked;
    int full_count;
    int miss_count;

    sorted_list_insert_delete i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sli_list_monitor i_monitor
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (error_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_count      (full_count),
        .miss_count      (miss_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    // ends the run if neither side moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_command(input logic [1:0] op, input value_t val,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pos, val, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        commands_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        value_t     pool[8];
        value_t     val;
        logic [1:0] op;
        int         roll;
        int         mode;
        int         burst;
        int         ins_pct;
        int         del_pct;
        int         sent_in_phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty list corner cases
        send_command(CMD_READ, 0, 4'd0);
        send_command(CMD_DELETE, 0, 4'd0);
        send_command(CMD_UNUSED, VAL_MAX, 4'hF);
        // fill to capacity with extremes and a duplicate
        send_command(CMD_INSERT, VAL_MAX, 4'd0);
        send_command(CMD_INSERT, VAL_MIN, 4'd0);
        send_command(CMD_INSERT, 0, 4'd0);
        send_command(CMD_INSERT, -1, 4'd0);
        send_command(CMD_INSERT, 0, 4'd0);
        send_command(CMD_INSERT, 1, 4'd0);
        for (int k = 0; k < 10; k++)
            send_command(CMD_INSERT, value_t'(k * 1000 - 5000), 4'd0);
        send_command(CMD_INSERT, 7, 4'd0);  // list full, rejected
        send_command(CMD_READ, 0, 4'hF);
        send_command(CMD_READ, 0, 4'd0);
        send_command(CMD_DELETE, VAL_MIN, 4'd0);
        send_command(CMD_DELETE, 12345, 4'd0);  // absent
        send_command(CMD_DELETE, 0, 4'd0);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                src_idle_pct   = 61;
                sink_idle_pct <= 13;
            end
            else if (phase == 2)
            begin
                src_idle_pct   = 0;
                sink_idle_pct <= 0;
            end
            // small pool so deletes hit and duplicates pile up
            pool[0] = VAL_MIN;
            pool[1] = VAL_MAX;
            pool[2] = 0;
            pool[3] = -1;
            for (int k = 4; k < 8; k++)
                pool[k] = value_t'($urandom_range(40)) - 20;

            sent_in_phase = 0;
            while (sent_in_phase < RANDOM_PER_PHASE)
            begin
                mode  = $urandom_range(2);  // 0 fill, 1 drain, 2 mixed
                burst = $urandom_range(8, 40);
                if (burst > RANDOM_PER_PHASE - sent_in_phase)
                    burst = RANDOM_PER_PHASE - sent_in_phase;
                pool[$urandom_range(4, 7)] = value_t'($urandom);
                ins_pct = (mode == 0) ? 70 : (mode == 1) ? 10 : 35;
                del_pct = (mode == 0) ? 10 : (mode == 1) ? 70 : 35;
                repeat (burst)
                begin
                    roll = $urandom_range(99);
                    if (roll < ins_pct)
                        op = CMD_INSERT;
                    else if (roll < ins_pct + del_pct)
                        op = CMD_DELETE;
                    else if (roll < 95)
                        op = CMD_READ;
                    else
                        op = CMD_UNUSED;
                    val = ($urandom_range(99) < 70) ? pool[$urandom_range(7)]
                                                    : value_t'($urandom);
                    send_command(op, val, POS_W'($urandom_range(15)));
                    sent_in_phase++;
                end
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d commands over three back-pressure mixes; %0d results checked,",
                 commands_sent, results_checked);
        $display("including %0d rejected inserts on a full list and %0d misses.",
                 full_count, miss_count);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete.sv
test/sli_list_monitor.sv
test/tb_sorted_list_insert_delete.sv
